// ===== design/x86il_pkg.sv =====
// ----------------------------------------------------------------------------
// x86il_pkg
// Shared types, constants and decode helpers for the x86-64 length decoder.
// ----------------------------------------------------------------------------
package x86il_pkg;

    localparam int MaxPrefixBytes = 14;
    localparam int WinBytes       = 17;
    localparam int QueueDepth     = 2;

    // One input transaction: the 17-byte instruction window.
    typedef struct packed {
        logic [7:0]  byte_last;
        logic [63:0] bytes_mid;
        logic [63:0] bytes_low;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic       invalid;
        logic [3:0] prefix_count;
        logic [4:0] length;
    } t_out_item;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        logic       too_many;
        logic [3:0] cnt;
        logic [7:0] op;
        logic [7:0] modrm;
        logic [7:0] sib;
        logic       o16;
        logic       a32;
        logic       rex_w;
    } t_cls_item;

    // Queue status seen by the front part.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // FPU check outcome.
    typedef enum logic [1:0] {
        FPU_OK       = 2'd0,
        FPU_INV_KEEP = 2'd1,
        FPU_INV_ONE  = 2'd2
    } t_fpu_res;

    // Queue occupancy states.
    typedef enum logic [1:0] {
        Q_EMPTY = 2'd0,
        Q_ONE   = 2'd1,
        Q_TWO   = 2'd2
    } t_q_state;

    localparam logic [7:0] PfxOpSize = 8'h66;
    localparam logic [7:0] PfxAdSize = 8'h67;
    localparam logic [7:0] PfxFs     = 8'h64;
    localparam logic [7:0] PfxRepne  = 8'hf2;
    localparam logic [7:0] PfxRep    = 8'hf3;
    localparam logic [7:0] PfxWait   = 8'h9b;
    localparam logic [7:0] PfxLock   = 8'hf0;
    localparam logic [7:0] RexWBit   = 8'h08;

    function automatic logic is_prefix(input logic [7:0] b);
        return b == PfxOpSize || b == PfxAdSize || b == PfxFs || b == PfxRepne ||
               b == PfxRep || b == PfxWait || b == PfxLock || b[7:4] == 4'h4;
    endfunction

    // Bytes of opcode, ModRM, SIB and displacement.
    function automatic logic [3:0] modrm_size(input logic [7:0] m, input logic [7:0] s);
        logic [3:0] n;
        n = 4'd2;
        if (m[7:6] == 2'd0 && m[2:0] == 3'd5) n = n + 4'd4;
        if (m[7:6] == 2'd1) n = n + 4'd1;
        if (m[7:6] == 2'd2) n = n + 4'd4;
        if (m[2:0] == 3'd4 && m[7:6] != 2'd3) begin
            n = n + 4'd1;
            if (m[7:6] == 2'd0 && s[2:0] == 3'd5) n = n + 4'd4;
        end
        return n;
    endfunction

    function automatic t_fpu_res fpu_check(input logic [2:0] opl, input logic [2:0] reg_f,
                                           input logic r3);
        t_fpu_res r;
        r = FPU_OK;
        case (opl)
            3'd0: if (reg_f == 3'd2) r = FPU_INV_ONE;
            3'd1: if (reg_f == 3'd4 || reg_f == 3'd5) r = FPU_INV_ONE;
            3'd2: if (r3 && (reg_f == 3'd4 || reg_f == 3'd6 || reg_f == 3'd7))
                      r = FPU_INV_KEEP;
            3'd3: begin
                if (reg_f == 3'd6) r = FPU_INV_ONE;
                else if (reg_f == 3'd4 && !r3) r = FPU_INV_KEEP;
                else if (reg_f == 3'd7 && r3) r = FPU_INV_KEEP;
            end
            3'd4: r = FPU_OK;
            3'd5: begin
                if (reg_f == 3'd5) r = r3 ? FPU_OK : FPU_INV_KEEP;
                else if (reg_f == 3'd1 || reg_f == 3'd6 || reg_f == 3'd7)
                    r = r3 ? FPU_INV_KEEP : FPU_OK;
            end
            3'd6: if (reg_f == 3'd2 && r3) r = FPU_INV_KEEP;
            default: if (r3 && (reg_f <= 3'd3 || reg_f == 3'd7)) r = FPU_INV_KEEP;
        endcase
        return r;
    endfunction

endpackage

// ===== design/x86il_front.sv =====
// ----------------------------------------------------------------------------
// x86il_front
// Counts and skips prefix bytes, then picks opcode, ModRM and SIB bytes.
// ----------------------------------------------------------------------------
module x86il_front import x86il_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_item,
    output logic      o_valid,
    output t_cls_item o_cls
);

    logic [7:0] win [WinBytes];
    logic [3:0] cnt;
    logic       stop;
    logic [7:0] leg;
    logic       rex_w;
    t_cls_item  cls;
    logic       r_valid;
    t_cls_item  r_cls;

    // Split the window into bytes.
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            win[k]     = i_item.bytes_low[8*k +: 8];
            win[k + 8] = i_item.bytes_mid[8*k +: 8];
        end
        win[16] = i_item.byte_last;
    end

    // Prefix scan: independent per-byte tests, first non-prefix wins.
    always_comb begin
        cnt   = 4'(MaxPrefixBytes);
        stop  = 1'b0;
        leg   = 8'h00;
        rex_w = 1'b0;
        for (int k = 0; k < MaxPrefixBytes; k++) begin
            if (!stop) begin
                if (is_prefix(win[k])) begin
                    if (win[k][7:4] == 4'h4) rex_w = (win[k] & RexWBit) != 8'h00;
                    else if (win[k] != PfxLock) leg = win[k];
                end else begin
                    stop = 1'b1;
                    cnt  = 4'(k);
                end
            end
        end
    end

    // Pick the opcode and the two following bytes.
    always_comb begin
        cls.too_many = !stop && is_prefix(win[MaxPrefixBytes]);
        cls.cnt      = cnt;
        cls.op       = win[5'(cnt)];
        cls.modrm    = win[5'(cnt) + 5'd1];
        cls.sib      = win[5'(cnt) + 5'd2];
        cls.o16      = leg == PfxOpSize;
        cls.a32      = leg == PfxAdSize;
        cls.rex_w    = rex_w;
    end

    // Register the classified transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_cls <= cls;
    end

    assign o_valid = r_valid;
    assign o_cls   = r_cls;

endmodule

// ===== design/x86il_queue.sv =====
// ----------------------------------------------------------------------------
// x86il_queue
// Two-entry queue between the classifying front part and the length back part.
// ----------------------------------------------------------------------------
module x86il_queue import x86il_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cls_item i_data,
    input  logic      i_pop,
    output t_cls_item o_data,
    output t_q_status o_status
);

    t_cls_item r_mem [QueueDepth];
    logic      r_wp;
    logic      r_rp;
    t_q_state  r_state;
    t_q_state  n_state;
    logic      do_push;
    logic      do_pop;

    assign do_push = i_push && r_state != Q_TWO;
    assign do_pop  = i_pop && r_state != Q_EMPTY;

    // Next occupancy.
    always_comb begin
        n_state = r_state;
        case (r_state)
            Q_EMPTY: if (do_push) n_state = Q_ONE;
            Q_ONE: begin
                if (do_push && !do_pop) n_state = Q_TWO;
                else if (!do_push && do_pop) n_state = Q_EMPTY;
            end
            Q_TWO: if (do_pop && !do_push) n_state = Q_ONE;
            default: n_state = Q_EMPTY;
        endcase
    end

    // Status outputs.
    always_comb begin
        o_status.full  = r_state == Q_TWO;
        o_status.empty = r_state == Q_EMPTY;
    end

    // Pointers and storage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= Q_EMPTY;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (do_push) r_wp <= ~r_wp;
            if (do_pop) r_rp <= ~r_rp;
        end
        if (do_push) r_mem[r_wp] <= i_data;
    end

    assign o_data = r_mem[r_rp];

    // The queue must never be pushed while full.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(i_push && r_state == Q_TWO))
        else $error("queue overflow");
    // A pop on a single entry with no push leaves the queue empty.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == Q_ONE && i_pop && !i_push) |=> r_state == Q_EMPTY)
        else $error("queue occupancy slip");
    // Pointers are equal whenever the queue is empty.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == Q_EMPTY |-> r_wp == r_rp)
        else $error("queue pointer mismatch");

endmodule

// ===== design/x86il_back.sv =====
// ----------------------------------------------------------------------------
// x86il_back
// Decodes the one-byte opcode map and registers the length result.
// ----------------------------------------------------------------------------
module x86il_back import x86il_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_cls_item i_cls,
    output logic      o_valid,
    output t_out_item o_result
);

    logic [7:0] op;
    logic [2:0] reg_f;
    logic       r3;
    logic [3:0] msz;
    logic [4:0] len;
    logic       bad;
    logic       inv;
    t_fpu_res   fr;
    logic [4:0] iv32;
    t_out_item  res;
    logic       r_valid;
    t_out_item  r_result;

    assign op    = i_cls.op;
    assign reg_f = i_cls.modrm[5:3];
    assign r3    = i_cls.modrm[7:6] == 2'd3;
    assign msz   = modrm_size(i_cls.modrm, i_cls.sib);
    assign fr    = fpu_check(op[2:0], reg_f, r3);
    assign iv32  = i_cls.o16 ? 5'd2 : 5'd4;

    // Opcode map decode.
    always_comb begin
        len = 5'd0;
        bad = 1'b0;
        inv = 1'b0;
        if (op <= 8'h3f) begin
            if (op[2:0] <= 3'd3) len = 5'(msz);
            else if (op[2:0] == 3'd4) len = 5'd2;
            else if (op[2:0] == 3'd5) len = 5'd5;
            else bad = 1'b1;
        end else if (op >= 8'h50 && op <= 8'h5f) len = 5'd1;
        else if (op >= 8'h70 && op <= 8'h7f) len = 5'd2;
        else if (op >= 8'h90 && op <= 8'h9f && op != 8'h9a) len = 5'd1;
        else if (op >= 8'hb0 && op <= 8'hb7) len = 5'd2;
        else if (op >= 8'hb8 && op <= 8'hbf) len = 5'd1 + (i_cls.rex_w ? 5'd8 : iv32);
        else if (op >= 8'hd8 && op <= 8'hdf) begin
            len = 5'(msz);
            if (fr == FPU_INV_KEEP) inv = 1'b1;
            else if (fr == FPU_INV_ONE) bad = 1'b1;
        end else begin
            case (op)
                8'h68, 8'h69: len = 5'd5;
                8'h6a, 8'h6b: len = 5'd2;
                8'h6c, 8'h6d, 8'h6e, 8'h6f: len = 5'd1;
                8'h80, 8'h83: len = 5'(msz) + 5'd1;
                8'h81: len = (i_cls.o16 ? 5'd2 : 5'd4) + 5'(msz);
                8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a, 8'h8b, 8'h8c, 8'h8e:
                    len = 5'(msz);
                8'h8d, 8'h8f: if (r3) bad = 1'b1; else len = 5'(msz);
                8'ha0, 8'ha1, 8'ha2, 8'ha3: len = i_cls.a32 ? 5'd5 : 5'd9;
                8'ha4, 8'ha5, 8'ha6, 8'ha7: len = 5'd1;
                8'ha8: len = 5'd2;
                8'ha9: len = 5'd1 + iv32;
                8'haa, 8'hab, 8'hac, 8'had, 8'hae, 8'haf: len = 5'd1;
                8'hc0, 8'hc1, 8'hd0, 8'hd1, 8'hd2, 8'hd3: begin
                    if (reg_f == 3'd2 || reg_f == 3'd3 || reg_f == 3'd6) bad = 1'b1;
                    else len = 5'(msz) + ((op <= 8'hc1) ? 5'd1 : 5'd0);
                end
                8'hc2: len = 5'd3;
                8'hc3: len = 5'd1;
                8'hc6: if (reg_f != 3'd0) bad = 1'b1; else len = 5'd1 + 5'(msz);
                8'hc7: if (reg_f != 3'd0) bad = 1'b1; else len = iv32 + 5'(msz);
                8'hc8: len = 5'd4;
                8'hc9: len = 5'd1;
                8'hca: len = 5'd3;
                8'hcb, 8'hcc: len = 5'd1;
                8'hcd: len = 5'd2;
                8'hcf: len = 5'd1;
                8'hd7: len = 5'd1;
                8'he0, 8'he1, 8'he2, 8'he3, 8'he4, 8'he5, 8'he6, 8'he7, 8'heb:
                    len = 5'd2;
                8'he8, 8'he9: len = 5'd1 + iv32;
                8'hec, 8'hed, 8'hee, 8'hef: len = 5'd1;
                8'hf4, 8'hf5: len = 5'd1;
                8'hf6, 8'hf7: begin
                    if (reg_f == 3'd1) bad = 1'b1;
                    else len = 5'(msz) + ((reg_f == 3'd0) ?
                               ((op == 8'hf6) ? 5'd1 : iv32) : 5'd0);
                end
                default: bad = 1'b1;
            endcase
        end
    end

    // Assemble the result transaction.
    always_comb begin
        if (i_cls.too_many) begin
            res.length       = 5'd1;
            res.prefix_count = 4'(MaxPrefixBytes);
            res.invalid      = 1'b1;
        end else begin
            res.length       = bad ? 5'd1 : 5'(i_cls.cnt) + len;
            res.prefix_count = i_cls.cnt;
            res.invalid      = bad | inv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_result <= res;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // An invalid result of length above one must come from an FPU slot.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_result.invalid && r_result.length != 5'd1) |->
        $past(i_cls.op[7:3]) == 5'b11011)
        else $error("invalid result keeps length outside FPU map");
    // Prefix count never exceeds the prefix limit.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_result.prefix_count <= 4'(MaxPrefixBytes))
        else $error("prefix count out of range");
    // Each accepted item yields one result next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_valid |=> r_valid)
        else $error("result lost");

endmodule

// ===== design/x86_64_instruction_length_decoder.sv =====
// The result strobe follows start through the front register, the queue and the result register.
// Throughput: one instruction per cycle; busy rises only when the queue is full.
// The receiver cannot stall, so the queue drains every cycle and busy stays low in use.
// Reset (synchronous, active low) empties the queue and clears all strobes.
// ----------------------------------------------------------------------------
// x86_64_instruction_length_decoder
// Top level: prefix front part, two-entry queue and opcode-map back part.
// ----------------------------------------------------------------------------
module x86_64_instruction_length_decoder import x86il_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_strobe,
    output t_out_item o_result
);

    logic      f_valid;
    t_cls_item f_cls;
    t_cls_item q_data;
    t_q_status q_status;
    logic      q_pop;

    assign busy  = q_status.full;
    assign q_pop = !q_status.empty;

    x86il_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_item  (i_item),
        .o_valid (f_valid),
        .o_cls   (f_cls)
    );

    x86il_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (f_valid),
        .i_data   (f_cls),
        .i_pop    (q_pop),
        .o_data   (q_data),
        .o_status (q_status)
    );

    x86il_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_pop),
        .i_cls    (q_data),
        .o_valid  (o_strobe),
        .o_result (o_result)
    );

endmodule
